// ===== src/sacl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared geometry, codes and helpers of the set-associative cache controller.
// ----------------------------------------------------------------------------
package sacl_pkg;

  function automatic int flog2(input int v);
    int r;
    r = 0;
    for (int i = 0; i < 31; i++) begin
      if ((v >> i) > 1) r = i + 1;
    end
    return r;
  endfunction

  localparam int SET_COUNT   = 64;
  localparam int WAYS        = 4;
  localparam int BLOCK_BYTES = 32;

  localparam int ADDR_BITS  = 32;
  localparam int OFF_BITS   = flog2(BLOCK_BYTES);
  localparam int IDX_BITS   = flog2(SET_COUNT);
  localparam int SHIFT      = OFF_BITS + IDX_BITS;
  localparam int TAG_BITS   = ADDR_BITS - SHIFT;
  localparam int SET_W      = (IDX_BITS > 0) ? IDX_BITS : 1;
  localparam int WAY_BITS   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int LINES      = SET_COUNT * WAYS;
  localparam int LINE_BITS  = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int STAMP_BITS = 32;
  localparam int LAT_BITS   = 10;
  localparam int COST_BITS  = 12;
  localparam int CFG_IDX_BITS = 3;

  // line word: tag, dirty flag, use stamp
  localparam int LINE_W = TAG_BITS + 1 + STAMP_BITS;

  localparam logic [ADDR_BITS-1:0] SET_MASK = ADDR_BITS'((64'd1 << IDX_BITS) - 64'd1);

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [1:0] FWD_NONE  = 2'd0;
  localparam logic [1:0] FWD_BLOCK = 2'd1;
  localparam logic [1:0] FWD_BYTE  = 2'd2;

  localparam logic [CFG_IDX_BITS-1:0] REG_WB_MODE    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_ALLOC_MODE = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_HIT_LAT    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_MISS_LAT   = 3'd3;

  typedef struct packed {
    logic [TAG_BITS-1:0]   tag;
    logic                  dirty;
    logic [STAMP_BITS-1:0] stamp;
  } line_t;

  function automatic logic [LINE_BITS-1:0] line_of(input logic [SET_W-1:0] set,
                                                   input logic [WAY_BITS-1:0] way);
    return LINE_BITS'(int'(set) * WAYS + int'(way));
  endfunction

endpackage

// ===== src/sacl_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacl_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    if (re) rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/set_assoc_cache_lru_controller_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_controller_top
// Tag lookup and LRU replacement controller of a set-associative cache.
//
//   channel | ports                       | direction | transaction
//   --------+-----------------------------+-----------+------------------------
//   in      | in_valid/in_ready, op, addr | input     | one byte access
//   out     | out_valid/out_ready, fields | output    | lookup result
//   cfg     | cfg_valid/cfg_ready, index  | input     | register write
//
// An access runs from accept to out_valid through S_READ and S_CMP for each
// way of the set in turn, the ways read one by one from a single line RAM
// through one tag/stamp comparator, and then through the S_UPDATE state.
// in_ready returns with out_valid, so the next access is taken only once S_UPDATE is left.
// Reset clears the valid flags at once; there is no clearing pass.
// S_UPDATE holds while a previous result waits in the output register.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_controller_top (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   in_op,
  input  logic [sacl_pkg::ADDR_BITS-1:0]         in_addr,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   out_hit,
  output logic [sacl_pkg::WAY_BITS-1:0]          out_way,
  output logic                                   out_fill_request,
  output logic                                   out_writeback_request,
  output logic [sacl_pkg::ADDR_BITS-1:0]         out_writeback_addr,
  output logic [1:0]                             out_forward_kind,
  output logic [sacl_pkg::COST_BITS-1:0]         out_access_cost,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [sacl_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [sacl_pkg::LAT_BITS-1:0]          cfg_data
);
  import sacl_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_READ   = 4'b0010,
    S_CMP    = 4'b0100,
    S_UPDATE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic                wb_mode_r, alloc_mode_r;
  logic [LAT_BITS-1:0] hit_lat_r, miss_lat_r;

  // access context
  logic                  op_r;
  logic [TAG_BITS-1:0]   tag_r;
  logic [SET_W-1:0]      set_r;
  logic [STAMP_BITS-1:0] use_ctr_r;
  logic [WAY_BITS-1:0]   cnt_r;

  // scan results
  logic                  hit_found_r, free_found_r, hit_dirty_r;
  logic [WAY_BITS-1:0]   hit_way_r, free_way_r, min_way_r;
  logic [STAMP_BITS-1:0] min_stamp_r;
  logic                  min_dirty_r;
  logic [TAG_BITS-1:0]   min_tag_r;

  logic [LINES-1:0] valid_r;

  // output register
  logic                  out_valid_r;
  logic                  out_hit_r, out_fill_r, out_wb_r;
  logic [WAY_BITS-1:0]   out_way_r;
  logic [ADDR_BITS-1:0]  out_wb_addr_r;
  logic [1:0]            out_fwd_r;
  logic [COST_BITS-1:0]  out_cost_r;

  logic [ADDR_BITS-1:0] set_full, tag_full;
  logic [LINE_BITS-1:0] scan_line, upd_line;
  logic                 ram_we, ram_re;
  line_t                ram_wdata, ram_rdata;
  logic [LINE_W-1:0]    ram_rword;
  logic                 in_fire, upd_go, last_way;
  logic                 cur_valid, tag_eq, stamp_lt;

  // update decision
  logic                 bypass, do_wb;
  logic [WAY_BITS-1:0]  upd_way;
  logic [COST_BITS-1:0] upd_cost;
  logic [1:0]           upd_fwd;
  logic [ADDR_BITS-1:0] upd_wb_addr;

  assign set_full = (in_addr >> OFF_BITS) & SET_MASK;
  assign tag_full = in_addr >> SHIFT;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign last_way  = (cnt_r == WAY_BITS'(WAYS - 1));
  assign upd_go    = (state_r == S_UPDATE) && (!out_valid_r || out_ready);

  assign scan_line = line_of(set_r, cnt_r);
  assign ram_re    = (state_r == S_READ);

  sacl_ram #(
    .WIDTH (LINE_W),
    .DEPTH (LINES)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (upd_line),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (scan_line),
    .rdata (ram_rword)
  );

  assign ram_rdata = line_t'(ram_rword);

  // shared comparator
  assign cur_valid = valid_r[scan_line];
  assign tag_eq    = (ram_rdata.tag == tag_r);
  assign stamp_lt  = (ram_rdata.stamp < min_stamp_r);

  always_comb begin
    bypass      = !hit_found_r && (op_r == OP_WRITE) && !alloc_mode_r;
    do_wb       = 1'b0;
    upd_way     = '0;
    upd_fwd     = FWD_NONE;
    upd_wb_addr = '0;
    upd_cost    = COST_BITS'(miss_lat_r);
    ram_wdata   = '{tag: tag_r, dirty: (op_r == OP_WRITE), stamp: use_ctr_r};
    if (hit_found_r) begin
      upd_way         = hit_way_r;
      upd_cost        = COST_BITS'(hit_lat_r);
      ram_wdata.dirty = hit_dirty_r || (op_r == OP_WRITE);
      if ((op_r == OP_WRITE) && !wb_mode_r) begin
        upd_fwd  = FWD_BLOCK;
        upd_cost = COST_BITS'(hit_lat_r) + COST_BITS'(miss_lat_r);
      end
    end else if (bypass) begin
      upd_fwd = FWD_BYTE;
    end else begin
      upd_way = free_found_r ? free_way_r : min_way_r;
      do_wb   = wb_mode_r && !free_found_r && min_dirty_r;
      if (do_wb) begin
        upd_wb_addr = (ADDR_BITS'(min_tag_r) << SHIFT) | (ADDR_BITS'(set_r) << OFF_BITS);
        upd_cost    = COST_BITS'(miss_lat_r) + COST_BITS'(miss_lat_r);
      end
    end
  end

  assign upd_line = line_of(set_r, upd_way);
  assign ram_we   = upd_go && !bypass;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_fire) state_nxt = S_READ;
      S_READ:   state_nxt = S_CMP;
      S_CMP:    state_nxt = last_way ? S_UPDATE : S_READ;
      S_UPDATE: if (upd_go) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      wb_mode_r    <= 1'b1;
      alloc_mode_r <= 1'b1;
      hit_lat_r    <= LAT_BITS'(1);
      miss_lat_r   <= LAT_BITS'(100);
      use_ctr_r    <= '0;
      valid_r      <= '0;
      out_valid_r  <= 1'b0;
      cnt_r        <= '0;
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_WB_MODE:    wb_mode_r    <= cfg_data[0];
          REG_ALLOC_MODE: alloc_mode_r <= cfg_data[0];
          REG_HIT_LAT:    hit_lat_r    <= cfg_data;
          REG_MISS_LAT:   miss_lat_r   <= cfg_data;
          default: ;
        endcase
      end

      if (in_fire) begin
        use_ctr_r    <= use_ctr_r + STAMP_BITS'(1);
        cnt_r        <= '0;
        hit_found_r  <= 1'b0;
        free_found_r <= 1'b0;
      end

      if (state_r == S_CMP) begin
        if (!last_way) cnt_r <= cnt_r + WAY_BITS'(1);
        if (cur_valid && tag_eq && !hit_found_r) hit_found_r <= 1'b1;
        if (!cur_valid && !free_found_r) free_found_r <= 1'b1;
      end

      if (upd_go) begin
        if (!bypass) valid_r[upd_line] <= 1'b1;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r  <= in_op;
      tag_r <= TAG_BITS'(tag_full);
      set_r <= SET_W'(set_full);
    end
    if (state_r == S_CMP) begin
      if (cur_valid && tag_eq && !hit_found_r) begin
        hit_way_r   <= cnt_r;
        hit_dirty_r <= ram_rdata.dirty;
      end
      if (!cur_valid && !free_found_r) free_way_r <= cnt_r;
      // lowest way wins ties
      if ((cnt_r == '0) || stamp_lt) begin
        min_stamp_r <= ram_rdata.stamp;
        min_way_r   <= cnt_r;
        min_dirty_r <= ram_rdata.dirty;
        min_tag_r   <= ram_rdata.tag;
      end
    end
    if (upd_go) begin
      out_hit_r     <= hit_found_r;
      out_way_r     <= upd_way;
      out_fill_r    <= !hit_found_r && !bypass;
      out_wb_r      <= do_wb;
      out_wb_addr_r <= upd_wb_addr;
      out_fwd_r     <= upd_fwd;
      out_cost_r    <= upd_cost;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_hit               = out_hit_r;
  assign out_way               = out_way_r;
  assign out_fill_request      = out_fill_r;
  assign out_writeback_request = out_wb_r;
  assign out_writeback_addr    = out_wb_addr_r;
  assign out_forward_kind      = out_fwd_r;
  assign out_access_cost       = out_cost_r;

endmodule

// ===== src/sacl_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacl_checker
// Port-level checks of the cache controller, bound to the top level.
// ----------------------------------------------------------------------------
module sacl_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic                                out_hit,
  input logic [sacl_pkg::WAY_BITS-1:0]       out_way,
  input logic                                out_fill_request,
  input logic                                out_writeback_request,
  input logic [sacl_pkg::ADDR_BITS-1:0]      out_writeback_addr,
  input logic [1:0]                          out_forward_kind,
  input logic [sacl_pkg::COST_BITS-1:0]      out_access_cost
);
  import sacl_pkg::*;

  // in_ready drops after a transaction is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("controller ready right after accepting a transaction");

  a_hit_no_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_hit && (out_fill_request || out_writeback_request)))
    else $error("hit reported together with fill or write-back");

  a_wb_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_writeback_request |-> out_writeback_addr == '0)
    else $error("write-back address set without write-back");

  a_bypass_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_forward_kind == FWD_BYTE)
      |-> !out_hit && !out_fill_request && !out_writeback_request && (out_way == '0))
    else $error("byte bypass result carries lookup activity");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_access_cost) && $stable(out_way))
    else $error("stalled result changed");

endmodule

bind set_assoc_cache_lru_controller_top sacl_checker u_sacl_checker (.*);

// ===== tb/sv/lru_lookup_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_lookup_check
// Watches the access, result and register channels of the cache controller.
// It keeps its own copy of tags, valid and dirty flags, use stamps and mode
// registers, works out the lookup result of every accepted access, and
// compares each delivered result field by field with the oldest one owed.
// ----------------------------------------------------------------------------
module lru_lookup_check
  import sacl_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic                    in_op,
  input  logic [ADDR_BITS-1:0]    in_addr,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic                    out_hit,
  input  logic [WAY_BITS-1:0]     out_way,
  input  logic                    out_fill_request,
  input  logic                    out_writeback_request,
  input  logic [ADDR_BITS-1:0]    out_writeback_addr,
  input  logic [1:0]              out_forward_kind,
  input  logic [COST_BITS-1:0]    out_access_cost,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [LAT_BITS-1:0]     cfg_data,
  output int                      bad_results,
  output int                      results_owed
);

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic                 hit;
    logic [WAY_BITS-1:0]  way;
    logic                 fill;
    logic                 wb;
    logic [ADDR_BITS-1:0] wb_addr;
    logic [1:0]           fwd;
    logic [COST_BITS-1:0] cost;
  } lookup_t;

  logic [TAG_BITS-1:0]   line_tag   [LINES];
  logic                  line_valid [LINES];
  logic                  line_dirty [LINES];
  logic [STAMP_BITS-1:0] line_stamp [LINES];
  logic [STAMP_BITS-1:0] use_count;

  logic                wb_mode;
  logic                alloc_mode;
  logic [LAT_BITS-1:0] hit_lat;
  logic [LAT_BITS-1:0] miss_lat;

  lookup_t owed_lookups[$];
  int      fails = 0;
  int      owed = 0;

  assign bad_results  = fails;
  assign results_owed = owed;

  function automatic lookup_t lookup_access(input logic op, input logic [ADDR_BITS-1:0] addr);
    lookup_t             r;
    logic [SET_W-1:0]    set_idx;
    logic [TAG_BITS-1:0] tag;
    int                  base;
    int                  hit_way;
    int                  victim;
    int                  i;
    r       = '0;
    set_idx = SET_W'(addr >> OFF_BITS);
    tag     = TAG_BITS'(addr >> SHIFT);
    base    = int'(set_idx) * WAYS;
    use_count = use_count + 1'b1;

    // descending scan so the lowest matching way wins
    hit_way = -1;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (line_valid[base + w] && line_tag[base + w] == tag) hit_way = w;
    end

    if (hit_way >= 0) begin
      i = base + hit_way;
      r.hit = 1'b1;
      r.way = WAY_BITS'(hit_way);
      r.cost = COST_BITS'(hit_lat);
      line_stamp[i] = use_count;
      if (op == OP_WRITE) begin
        line_dirty[i] = 1'b1;
        if (!wb_mode) begin
          r.fwd  = FWD_BLOCK;
          r.cost = r.cost + COST_BITS'(miss_lat);
        end
      end
    end else if (op == OP_WRITE && !alloc_mode) begin
      // write around: set left untouched
      r.fwd  = FWD_BYTE;
      r.cost = COST_BITS'(miss_lat);
    end else begin
      r.fill = 1'b1;
      r.cost = COST_BITS'(miss_lat);
      victim = -1;
      for (int w = WAYS - 1; w >= 0; w--) begin
        if (!line_valid[base + w]) victim = w;
      end
      if (victim < 0) begin
        // oldest stamp, strict compare keeps the lowest way on ties
        victim = 0;
        for (int w = 1; w < WAYS; w++) begin
          if (line_stamp[base + w] < line_stamp[base + victim]) victim = w;
        end
      end
      i = base + victim;
      r.way = WAY_BITS'(victim);
      if (wb_mode && line_valid[i] && line_dirty[i]) begin
        r.wb      = 1'b1;
        r.wb_addr = (ADDR_BITS'(line_tag[i]) << SHIFT) | (ADDR_BITS'(set_idx) << OFF_BITS);
        r.cost    = r.cost + COST_BITS'(miss_lat);
      end
      line_tag[i]   = tag;
      line_valid[i] = 1'b1;
      line_dirty[i] = (op == OP_WRITE);
      line_stamp[i] = use_count;
    end
    return r;
  endfunction

  function automatic string describe(input lookup_t r);
    return $sformatf("hit=%0d way=%0d fill=%0d wb=%0d wb_addr=%08h fwd=%0d cost=%0d",
                     r.hit, r.way, r.fill, r.wb, r.wb_addr, r.fwd, r.cost);
  endfunction

  always @(posedge clk) begin
    lookup_t got;
    lookup_t want;
    if (!rst_n) begin
      for (int i = 0; i < LINES; i++) begin
        line_tag[i]   = '0;
        line_valid[i] = 1'b0;
        line_dirty[i] = 1'b0;
        line_stamp[i] = '0;
      end
      use_count  = '0;
      wb_mode    = 1'b1;
      alloc_mode = 1'b1;
      hit_lat    = LAT_BITS'(1);
      miss_lat   = LAT_BITS'(100);
    end else begin
      if (out_valid && out_ready) begin
        got.hit     = out_hit;
        got.way     = out_way;
        got.fill    = out_fill_request;
        got.wb      = out_writeback_request;
        got.wb_addr = out_writeback_addr;
        got.fwd     = out_forward_kind;
        got.cost    = out_access_cost;
        if (owed_lookups.size() == 0) begin
          fails++;
          if (fails <= REPORT_LIMIT)
            $display("%0t: result with no access pending: %s", $time, describe(got));
        end else begin
          want = owed_lookups.pop_front();
          owed--;
          if (got.hit !== want.hit || got.way !== want.way || got.fill !== want.fill ||
              got.wb !== want.wb || got.wb_addr !== want.wb_addr ||
              got.fwd !== want.fwd || got.cost !== want.cost) begin
            fails++;
            if (fails <= REPORT_LIMIT) begin
              $display("%0t: lookup mismatch", $time);
              $display("  expected %s", describe(want));
              $display("  actual   %s", describe(got));
            end
          end
        end
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WB_MODE:    wb_mode    = cfg_data[0];
          REG_ALLOC_MODE: alloc_mode = cfg_data[0];
          REG_HIT_LAT:    hit_lat    = cfg_data;
          REG_MISS_LAT:   miss_lat   = cfg_data;
          default: ;
        endcase
      end

      if (in_valid && in_ready) begin
        owed_lookups.push_back(lookup_access(in_op, in_addr));
        owed++;
      end
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives byte accesses and register writes into the cache controller: a
// directed opening through fills, hits, dirty evictions, write-through and
// write-around, then random phases over small pools of sets and tags so that
// sets fill up and evict, under every mode and the latency extremes.
// ----------------------------------------------------------------------------
module tb_top;
  import sacl_pkg::*;

  localparam int RESET_CYCLES   = 8;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ACCESSES = 210;
  localparam int SET_POOL_SIZE  = 6;
  localparam int TAG_POOL_MAX   = 8;
  localparam int SETTLE_CYCLES  = 4 * (2 * WAYS + 2);
  localparam int CYCLE_LIMIT    = 1_000_000;

  typedef enum int {RX_OPEN, RX_CHOPPY, RX_CLOGGED} rx_mode_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic                    in_op;
  logic [ADDR_BITS-1:0]    in_addr;
  logic                    out_valid;
  logic                    out_ready;
  logic                    out_hit;
  logic [WAY_BITS-1:0]     out_way;
  logic                    out_fill_request;
  logic                    out_writeback_request;
  logic [ADDR_BITS-1:0]    out_writeback_addr;
  logic [1:0]              out_forward_kind;
  logic [COST_BITS-1:0]    out_access_cost;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [LAT_BITS-1:0]     cfg_data;

  int bad_results;
  int results_owed;
  int cycle_count = 0;
  int burst_left = 0;

  logic [TAG_BITS-1:0] tag_pool [TAG_POOL_MAX];
  logic [SET_W-1:0]    set_pool [SET_POOL_SIZE];
  int                  tag_pool_size;

  set_assoc_cache_lru_controller_top dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_op                 (in_op),
    .in_addr               (in_addr),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_hit               (out_hit),
    .out_way               (out_way),
    .out_fill_request      (out_fill_request),
    .out_writeback_request (out_writeback_request),
    .out_writeback_addr    (out_writeback_addr),
    .out_forward_kind      (out_forward_kind),
    .out_access_cost       (out_access_cost),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  lru_lookup_check u_check (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_op                 (in_op),
    .in_addr               (in_addr),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_hit               (out_hit),
    .out_way               (out_way),
    .out_fill_request      (out_fill_request),
    .out_writeback_request (out_writeback_request),
    .out_writeback_addr    (out_writeback_addr),
    .out_forward_kind      (out_forward_kind),
    .out_access_cost       (out_access_cost),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .bad_results           (bad_results),
    .results_owed          (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[set_assoc_cache_lru_controller_top] ERROR");
      $finish;
    end
  end

  // result side back-pressure: open, choppy and clogged stretches
  initial begin
    rx_mode_t rx_mode;
    int       rx_left;
    rx_mode = RX_OPEN;
    rx_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 2));
        rx_left = $urandom_range(16, 160);
      end
      rx_left--;
      case (rx_mode)
        RX_OPEN:    out_ready <= 1'b1;
        RX_CHOPPY:  out_ready <= ($urandom_range(0, 1) == 1);
        RX_CLOGGED: out_ready <= ($urandom_range(0, 7) == 0);
        default:    out_ready <= 1'b1;
      endcase
    end
  end

  function automatic logic [ADDR_BITS-1:0] addr_of(input logic [TAG_BITS-1:0] tag,
                                                   input logic [SET_W-1:0] set_idx,
                                                   input logic [OFF_BITS-1:0] off);
    return (ADDR_BITS'(tag) << SHIFT) | (ADDR_BITS'(set_idx) << OFF_BITS) | ADDR_BITS'(off);
  endfunction

  // called and returns at a falling edge; valid stays up across a burst
  task automatic send_access(input logic op, input logic [ADDR_BITS-1:0] addr);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_op    <= op;
    in_addr  <= addr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [LAT_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // registers change only with the controller idle
  task automatic load_config(input logic wb, input logic alloc,
                             input logic [LAT_BITS-1:0] hit_lat,
                             input logic [LAT_BITS-1:0] miss_lat);
    logic [LAT_BITS-1:0] junk;
    drain();
    junk = LAT_BITS'($urandom);
    write_reg(REG_WB_MODE, {junk[LAT_BITS-1:1], wb});
    junk = LAT_BITS'($urandom);
    write_reg(REG_ALLOC_MODE, {junk[LAT_BITS-1:1], alloc});
    write_reg(REG_HIT_LAT, hit_lat);
    write_reg(REG_MISS_LAT, miss_lat);
    // unused index, must be dropped
    write_reg(CFG_IDX_BITS'(int'(REG_MISS_LAT) + 1 + $urandom_range(0, 3)),
              LAT_BITS'($urandom));
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic                 wb;
    logic                 alloc;
    logic [LAT_BITS-1:0]  hit_lat;
    logic [LAT_BITS-1:0]  miss_lat;
    logic [ADDR_BITS-1:0] addr;
    logic                 op;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_op     <= OP_READ;
    in_addr   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_WB_MODE;
    cfg_data  <= '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // reset modes: write-back, write-allocate
    send_access(OP_READ,  addr_of('0, '0, '0));
    send_access(OP_READ,  addr_of('1, '1, '1));
    send_access(OP_WRITE, addr_of('0, '0, '1));
    for (int t = 1; t <= 3; t++) send_access(OP_READ, addr_of(TAG_BITS'(t), '0, '0));
    // set full: dirty way 0 is oldest and goes back
    send_access(OP_READ,  addr_of(TAG_BITS'(4), '0, '0));
    send_access(OP_WRITE, addr_of(TAG_BITS'(5), '0, '0));
    send_access(OP_READ,  addr_of('1, '1, '0));

    // write-through, write-around, zero latencies
    load_config(1'b0, 1'b0, '0, '0);
    send_access(OP_WRITE, addr_of(TAG_BITS'(2), '0, '0));
    send_access(OP_WRITE, 32'h1234_5678);
    send_access(OP_READ,  addr_of(TAG_BITS'(6), '0, '0));

    // write-through with allocation leaves a dirty line behind
    load_config(1'b0, 1'b1, '1, '1);
    send_access(OP_WRITE, addr_of(TAG_BITS'(1) << (TAG_BITS - 1), SET_W'(2), '0));
    send_access(OP_WRITE, addr_of(TAG_BITS'(1) << (TAG_BITS - 1), SET_W'(2), OFF_BITS'(1)));

    // back to write-back: that line is evicted with a write-back
    load_config(1'b1, 1'b1, '1, '1);
    send_access(OP_READ, addr_of(TAG_BITS'(1), SET_W'(2), '0));
    send_access(OP_READ, addr_of(TAG_BITS'(2), SET_W'(2), '0));
    send_access(OP_READ, addr_of(TAG_BITS'(3), SET_W'(2), '0));
    send_access(OP_READ, addr_of(TAG_BITS'(5), SET_W'(2), '0));

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wb    = p[0];
      alloc = p[1];
      case (p)
        0: begin
          hit_lat  = '0;
          miss_lat = '0;
        end
        1: begin
          hit_lat  = '1;
          miss_lat = '1;
        end
        2: begin
          hit_lat  = LAT_BITS'(1);
          miss_lat = LAT_BITS'(100);
        end
        default: begin
          hit_lat  = LAT_BITS'($urandom);
          miss_lat = LAT_BITS'($urandom);
        end
      endcase
      load_config(wb, alloc, hit_lat, miss_lat);

      // small pools keep sets full and lines coming back
      tag_pool_size = $urandom_range(2, TAG_POOL_MAX);
      for (int k = 0; k < TAG_POOL_MAX; k++) tag_pool[k] = TAG_BITS'($urandom);
      if ($urandom_range(0, 1) == 1) tag_pool[0] = '0;
      else tag_pool[0] = '1;
      set_pool[0] = '0;
      set_pool[1] = '1;
      for (int k = 2; k < SET_POOL_SIZE; k++) set_pool[k] = SET_W'($urandom);

      repeat (PHASE_ACCESSES) begin
        op = ($urandom_range(0, 1) == 1) ? OP_WRITE : OP_READ;
        if ($urandom_range(0, 9) < 2) begin
          addr = ADDR_BITS'($urandom);
        end else begin
          addr = addr_of(tag_pool[$urandom_range(0, tag_pool_size - 1)],
                         set_pool[$urandom_range(0, SET_POOL_SIZE - 1)],
                         OFF_BITS'($urandom));
        end
        send_access(op, addr);
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (bad_results == 0 && results_owed == 0) begin
      $display("[set_assoc_cache_lru_controller_top] OK");
    end else begin
      $display("[set_assoc_cache_lru_controller_top] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/sacl_pkg.sv
src/sacl_ram.sv
src/set_assoc_cache_lru_controller_top.sv
src/sacl_checker.sv
tb/sv/lru_lookup_check.sv
tb/sv/tb_top.sv
